### sv/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// Holds action and status codes and the result record passed from the pointer
// control to the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Default sizing of the ring store.
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Fixed port field widths.
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned PORT_DATA_W = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Action codes carried by an input transaction.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ_FRONT = 3'd4,
    ACT_READ_BACK  = 3'd5,
    ACT_REVERSE    = 3'd6
  } action_e;

  // Status codes returned with every result transaction.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Result of one action, apart from the word read from the store.
  typedef struct packed {
    status_e                  status;
    logic [COUNT_OUT_W-1:0]   count_after;
    logic                     is_empty;
    logic                     need_read;
  } result_t;

endpackage

`default_nettype wire

### sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: handshake, read sequencing and
// output register. Depends on deq_pkg, deq_ptr and deq_store.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i / in_stall_o action_i, push_value_i
//   output   out        out_valid_o / out_stall_i read_value_o, status_o,
//                                               count_after_o, is_empty_o
//
// Push, pop, reverse and any action that fails go straight to the output register.
// A successful read waits on the store: the ring store has one synchronous read
// port with registered read data, and the input stalls while the read waits.
// Reset clears the head slot, the entry count and the direction flag; the
// store itself is not cleared and is read only at slots holding live entries.
// A new input transaction is taken while the output register is drained in the
// same cycle; a stalled output holds its result and stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned CAPACITY   = deq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [deq_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [deq_pkg::PORT_DATA_W-1:0] push_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [deq_pkg::PORT_DATA_W-1:0] read_value_o,
  output logic      [deq_pkg::STATUS_W-1:0]    status_o,
  output logic      [deq_pkg::COUNT_OUT_W-1:0] count_after_o,
  output logic                                 is_empty_o
);

  import deq_pkg::*;

  localparam int unsigned IdxW   = $clog2(CAPACITY);
  localparam int unsigned StoreW = (DATA_WIDTH < PORT_DATA_W) ? DATA_WIDTH : PORT_DATA_W;

  typedef enum logic {
    S_IDLE,
    S_WAIT_RD
  } state_e;

  state_e                   state_q;
  logic                     out_valid_q;
  logic [PORT_DATA_W-1:0]   read_value_q;
  logic [STATUS_W-1:0]      status_q;
  logic [COUNT_OUT_W-1:0]   count_after_q;
  logic                     is_empty_q;
  result_t                  pend_q;

  logic                     accept;
  logic                     wr_en, rd_en;
  logic [IdxW-1:0]          wr_addr, rd_addr;
  logic [StoreW-1:0]        rd_data;
  result_t                  res;

  // Input is held while a read waits on the store or the output is stalled.
  assign in_stall_o = (state_q == S_WAIT_RD) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  deq_ptr #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IdxW)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept),
    .action_i  (action_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  deq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (StoreW),
    .AW    (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (push_value_i[StoreW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Read sequencing and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      read_value_q  <= '0;
      status_q      <= '0;
      count_after_q <= '0;
      is_empty_q    <= 1'b0;
      pend_q        <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // An accepted transaction finds the output register free or draining.
          if (accept) begin
            if (res.need_read) begin
              out_valid_q <= 1'b0;
              pend_q      <= res;
              state_q     <= S_WAIT_RD;
            end else begin
              out_valid_q   <= 1'b1;
              read_value_q  <= '0;
              status_q      <= res.status;
              count_after_q <= res.count_after;
              is_empty_q    <= res.is_empty;
            end
          end else if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_WAIT_RD: begin
          out_valid_q   <= 1'b1;
          read_value_q  <= PORT_DATA_W'(rd_data);
          status_q      <= pend_q.status;
          count_after_q <= pend_q.count_after;
          is_empty_q    <= pend_q.is_empty;
          state_q       <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign count_after_o = count_after_q;
  assign is_empty_o    = is_empty_q;

  // The output register is empty whenever a store read is in flight.
  a_wait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT_RD) |-> !out_valid_q) else $error("read result would overwrite output");

  // A store read always delivers a result in the next cycle.
  a_wait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT_RD) |=> out_valid_q && (state_q == S_IDLE))
    else $error("store read did not complete");

  // Only a successful read goes to the store.
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.need_read |-> res.status == STAT_OK && rd_en)
    else $error("store read issued for a failed action");

endmodule

`default_nettype wire

### sv/deq_store.sv
// Ring store of the double-ended queue: one write port and one read port,
// read data registered and shown in the cycle after the address. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module deq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### sv/deq_ptr.sv
// Pointer control of the double-ended queue: head slot, entry count and
// direction flag, action decode and store addressing. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ptr #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire logic [deq_pkg::ACTION_W-1:0] action_i,
  output logic                              wr_en_o,
  output logic      [IDX_W-1:0]             wr_addr_o,
  output logic                              rd_en_o,
  output logic      [IDX_W-1:0]             rd_addr_o,
  output deq_pkg::result_t                  res_o
);

  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [SumW-1:0]  CapSum  = SumW'(CAPACITY);
  localparam logic [CntW-1:0]  CapCnt  = CntW'(CAPACITY);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CAPACITY - 1);

  logic [IDX_W-1:0] head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rev_q, rev_d;

  action_e          act;
  logic [IDX_W-1:0] head_inc, head_dec, tail_idx, last_idx;
  logic [SumW-1:0]  tail_sum, tail_wrap, last_sum, last_wrap;
  logic             full, empty, front_is_low, use_low;
  logic             wr_req, rd_req;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  status_e          status;
  logic [CntW+COUNT_OUT_W-1:0] cnt_ext;

  assign act = action_e'(action_i);

  // Neighbor slots of the ring, with wrap at the capacity.
  assign head_inc  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec  = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign tail_sum  = SumW'(head_q) + SumW'(cnt_q);
  assign tail_wrap = (tail_sum >= CapSum) ? tail_sum - CapSum : tail_sum;
  assign tail_idx  = tail_wrap[IDX_W-1:0];
  assign last_sum  = tail_sum - 1'b1;
  assign last_wrap = (last_sum >= CapSum) ? last_sum - CapSum : last_sum;
  assign last_idx  = last_wrap[IDX_W-1:0];

  assign full         = (cnt_q == CapCnt);
  assign empty        = (cnt_q == '0);
  assign front_is_low = !rev_q;

  // Action decode: next pointer state, store access and status.
  always_comb begin
    head_d  = head_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    wr_req  = 1'b0;
    wr_addr = tail_idx;
    rd_req  = 1'b0;
    rd_addr = head_q;
    status  = STAT_OK;
    use_low = 1'b0;
    unique case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        use_low = (act == ACT_PUSH_FRONT) ? front_is_low : !front_is_low;
        if (full) begin
          status = STAT_FULL;
        end else begin
          wr_req  = 1'b1;
          wr_addr = use_low ? head_dec : tail_idx;
          head_d  = use_low ? head_dec : head_q;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        use_low = (act == ACT_POP_FRONT) ? front_is_low : !front_is_low;
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          head_d = use_low ? head_inc : head_q;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      ACT_READ_FRONT, ACT_READ_BACK: begin
        use_low = (act == ACT_READ_FRONT) ? front_is_low : !front_is_low;
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          rd_req  = 1'b1;
          rd_addr = use_low ? head_q : last_idx;
        end
      end
      ACT_REVERSE: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          rev_d = !rev_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Pointer state advances only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      rev_q  <= 1'b0;
    end else if (go_i) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      rev_q  <= rev_d;
    end
  end

  assign wr_en_o   = go_i && wr_req;
  assign wr_addr_o = wr_addr;
  assign rd_en_o   = go_i && rd_req;
  assign rd_addr_o = rd_addr;

  // The count port keeps the low bits of the entry count.
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_d};

  assign res_o.status      = status;
  assign res_o.count_after = cnt_ext[COUNT_OUT_W-1:0];
  assign res_o.is_empty    = (cnt_d == '0);
  assign res_o.need_read   = rd_req;

  // The count never passes the capacity and the head stays inside the ring.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt) else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastIdx) else $error("head slot outside the ring");

  // A push into a full queue must leave the count unchanged.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && full && (act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT) |=> $stable(cnt_q))
    else $error("count changed on push into a full queue");

endmodule

`default_nettype wire
